// ===== sv/gcf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the 3x3 grayscale convolution filter
// no dependencies
package gcf_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int COEF_W     = 12;
    localparam int TAPS       = 3;
    localparam int COEF_ROW_W = COEF_W * TAPS;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;
    localparam int SUM_W      = PROD_W + 4;
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [DIM_W-1:0]      RST_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]      RST_HEIGHT   = 13'd480;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_TOP = 36'd0;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_MID = 36'd256;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_BOT = 36'd0;

    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_COEF_TOP = 3'd2,
        REG_COEF_MID = 3'd3,
        REG_COEF_BOT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]                 image_width;
        logic [DIM_W-1:0]                 image_height;
        logic [TAPS-1:0][COEF_ROW_W-1:0]  coef;
    } t_cfg;

    typedef struct packed {
        logic has_a;
        logic border_a;
        logic has_b;
        logic has_c;
        logic eoi;
    } t_flags;

    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               clamped;
        logic               eoi;
    } t_result;

endpackage

// ===== sv/grayscale_conv3x3_filter_unit.sv =====
`timescale 1ns / 1ps
// 3x3 convolution filter over a raster-order 8-bit grayscale stream. One pixel
// is accepted per clock while o_in_ready is high; each pixel yields zero to three
// result beats and the output delivers one beat per clock while i_out_ready is
// high, so pixels that yield two or three beats (last column or last row) hold
// the input back. A pixel passes the input, product, sum and result slot
// registers before its first beat. The two line stores are MAX_WIDTH x 8 rams,
// read and written once per pixel; the 9-tap multiply and the adder tree are
// separate pipeline stages. No clearing pass is needed after reset.
// depends on gcf_pkg, gcf_regs, gcf_line_buf, gcf_mac, gcf_emit
module grayscale_conv3x3_filter_unit import gcf_pkg::*; #(
    parameter int MAX_WIDTH      = 4096,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [COORD_W-1:0]    o_out_row,
    output logic [COORD_W-1:0]    o_out_col,
    output logic                  o_clamped,
    output logic                  o_last_of_run,
    output logic                  o_end_of_image
);

    localparam int ColW   = $clog2(MAX_WIDTH);
    localparam int NegLim = -(1 << COEF_FRAC_BITS);
    localparam int PosLim = (1 << PIX_W) << COEF_FRAC_BITS;

    t_cfg cfg;

    logic [ColW-1:0]    w_m1;
    logic [COORD_W-1:0] h_m1;
    logic [ColW-1:0]    r_col;
    logic [COORD_W-1:0] r_row;
    logic [ColW-1:0]    cur_c;
    logic [COORD_W-1:0] cur_r;
    logic               accept;
    t_flags             n_flags;

    logic               r_v1, r_v2, r_v3;
    logic               adv1, adv2, adv3;
    t_flags             r_f1, r_f2, r_f3;
    logic [PIX_W-1:0]   r_px1, r_px2, r_px3;
    logic [PIX_W-1:0]   r_mid2, r_mid3;
    logic [COORD_W-1:0] r_row1, r_row2, r_row3;
    logic [ColW-1:0]    r_col1, r_col2, r_col3;

    logic [PIX_W-1:0]        top_px;
    logic [PIX_W-1:0]        mid_px;
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0]        center;
    logic [PIX_W-1:0]        sat_pix;
    logic                    sat_clamp;
    logic                    can_load;
    t_result                 res [3];

    gcf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // effective image size, saturated to the supported range
    always_comb begin
        if (cfg.image_width < DIM_W'(2)) begin
            w_m1 = ColW'(1);
        end else if (32'(cfg.image_width) > MAX_WIDTH) begin
            w_m1 = ColW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = ColW'(cfg.image_width - DIM_W'(1));
        end
        if (cfg.image_height < DIM_W'(2)) begin
            h_m1 = COORD_W'(1);
        end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
            h_m1 = COORD_W'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = COORD_W'(cfg.image_height - DIM_W'(1));
        end
    end

    assign cur_c = (r_col > w_m1) ? w_m1 : r_col;
    assign cur_r = (r_row > h_m1) ? h_m1 : r_row;

    always_comb begin
        n_flags.has_a    = (cur_r != '0) && (cur_c != '0);
        n_flags.border_a = (cur_r == COORD_W'(1)) || (cur_c == ColW'(1));
        n_flags.has_b    = (cur_r != '0) && (cur_c == w_m1);
        n_flags.has_c    = (cur_r == h_m1);
        n_flags.eoi      = (cur_c == w_m1);
    end

    assign adv3       = r_v3 && can_load;
    assign adv2       = r_v2 && (!r_v3 || adv3);
    assign adv1       = r_v1 && (!r_v2 || adv2);
    assign o_in_ready = !r_v1 || adv1;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            if (accept) begin
                if (cur_c >= w_m1) begin
                    r_col <= '0;
                    r_row <= (cur_r >= h_m1) ? '0 : cur_r + COORD_W'(1);
                end else begin
                    r_col <= cur_c + ColW'(1);
                    r_row <= cur_r;
                end
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1   <= n_flags;
            r_px1  <= i_pixel_in;
            r_row1 <= cur_r;
            r_col1 <= cur_c;
        end
        if (adv1) begin
            r_f2   <= r_f1;
            r_px2  <= r_px1;
            r_mid2 <= mid_px;
            r_row2 <= r_row1;
            r_col2 <= r_col1;
        end
        if (adv2) begin
            r_f3   <= r_f2;
            r_px3  <= r_px2;
            r_mid3 <= r_mid2;
            r_row3 <= r_row2;
            r_col3 <= r_col2;
        end
    end

    // read at acceptance, write back older <- newer, newer <- pixel when it leaves the first stage
    gcf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (cur_c),
        .o_older    (top_px),
        .o_newer    (mid_px),
        .i_wr_en    (adv1),
        .i_wr_addr  (r_col1),
        .i_wr_older (mid_px),
        .i_wr_newer (r_px1)
    );

    gcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en_s2  (adv1),
        .i_en_s3  (adv2),
        .i_top    (top_px),
        .i_mid    (mid_px),
        .i_px     (r_px1),
        .i_cfg    (cfg),
        .o_sum    (sum),
        .o_center (center)
    );

    // truncate toward zero, then saturate to the pixel range
    always_comb begin
        if (sum <= NegLim) begin
            sat_pix   = '0;
            sat_clamp = 1'b1;
        end else if (sum[SUM_W-1]) begin
            sat_pix   = '0;
            sat_clamp = 1'b0;
        end else if (sum >= PosLim) begin
            sat_pix   = '1;
            sat_clamp = 1'b1;
        end else begin
            sat_pix   = sum[COEF_FRAC_BITS +: PIX_W];
            sat_clamp = 1'b0;
        end
    end

    always_comb begin
        res[0].pix     = r_f3.border_a ? center : sat_pix;
        res[0].row     = r_row3 - COORD_W'(1);
        res[0].col     = COORD_W'(r_col3 - ColW'(1));
        res[0].clamped = !r_f3.border_a && sat_clamp;
        res[0].eoi     = 1'b0;

        res[1].pix     = r_mid3;
        res[1].row     = r_row3 - COORD_W'(1);
        res[1].col     = COORD_W'(r_col3);
        res[1].clamped = 1'b0;
        res[1].eoi     = 1'b0;

        res[2].pix     = r_px3;
        res[2].row     = r_row3;
        res[2].col     = COORD_W'(r_col3);
        res[2].clamped = 1'b0;
        res[2].eoi     = r_f3.eoi;
    end

    gcf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (adv3),
        .i_res          (res),
        .i_mask         ({r_f3.has_c, r_f3.has_b, r_f3.has_a}),
        .o_can_load     (can_load),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_clamped      (o_clamped),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_image (o_end_of_image)
    );

endmodule

// ===== sv/gcf_regs.sv =====
`timescale 1ns / 1ps
// configuration register bank behind the apb-style port
// depends on gcf_pkg
module gcf_regs import gcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.coef[0]      <= RST_COEF_TOP;
            r_cfg.coef[1]      <= RST_COEF_MID;
            r_cfg.coef[2]      <= RST_COEF_BOT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:    r_cfg.image_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_cfg.image_height <= pwdata[DIM_W-1:0];
                REG_COEF_TOP: r_cfg.coef[0]      <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_MID: r_cfg.coef[1]      <= pwdata[COEF_ROW_W-1:0];
                REG_COEF_BOT: r_cfg.coef[2]      <= pwdata[COEF_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:    prdata = APB_DATA_W'(r_cfg.image_width);
            REG_HEIGHT:   prdata = APB_DATA_W'(r_cfg.image_height);
            REG_COEF_TOP: prdata = APB_DATA_W'(r_cfg.coef[0]);
            REG_COEF_MID: prdata = APB_DATA_W'(r_cfg.coef[1]);
            REG_COEF_BOT: prdata = APB_DATA_W'(r_cfg.coef[2]);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== sv/gcf_line_buf.sv =====
`timescale 1ns / 1ps
// the two line stores: synchronous rams, one read and one write per cycle
// depends on gcf_pkg
module gcf_line_buf import gcf_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic [PIX_W-1:0]             o_older,
    output logic [PIX_W-1:0]             o_newer,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]             i_wr_older,
    input  logic [PIX_W-1:0]             i_wr_newer
);

    logic [PIX_W-1:0] r_older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_older;
    logic [PIX_W-1:0] r_rd_newer;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_older_mem[i_wr_addr] <= i_wr_older;
            r_newer_mem[i_wr_addr] <= i_wr_newer;
        end
        if (i_rd_en) begin
            r_rd_older <= r_older_mem[i_rd_addr];
            r_rd_newer <= r_newer_mem[i_rd_addr];
        end
    end

    assign o_older = r_rd_older;
    assign o_newer = r_rd_newer;

endmodule

// ===== sv/gcf_mac.sv =====
`timescale 1ns / 1ps
// 3x3 window, product stage and sum stage of the convolution
// depends on gcf_pkg
module gcf_mac import gcf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en_s2,
    input  logic                    i_en_s3,
    input  logic [PIX_W-1:0]        i_top,
    input  logic [PIX_W-1:0]        i_mid,
    input  logic [PIX_W-1:0]        i_px,
    input  t_cfg                    i_cfg,
    output logic signed [SUM_W-1:0] o_sum,
    output logic [PIX_W-1:0]        o_center
);

    localparam int NWIN = TAPS * TAPS;

    logic [PIX_W-1:0]         r_win  [NWIN];
    logic [PIX_W-1:0]         n_win  [NWIN];
    logic signed [PROD_W-1:0] r_prod [NWIN];
    logic [PIX_W-1:0]         r_ctr2;
    logic [PIX_W-1:0]         r_ctr3;
    logic signed [SUM_W-1:0]  r_sum;

    // shift left one column, new column from the line stores and the input
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NWIN; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_en_s2) begin
            for (int k = 0; k < NWIN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_s2) begin
            for (int i = 0; i < TAPS; i++) begin
                for (int j = 0; j < TAPS; j++) begin
                    r_prod[i*TAPS+j] <= $signed({1'b0, n_win[i*TAPS+j]})
                                      * $signed(i_cfg.coef[i][j*COEF_W +: COEF_W]);
                end
            end
            r_ctr2 <= n_win[4];
        end
        if (i_en_s3) begin
            r_sum  <= (r_prod[0] + r_prod[1] + r_prod[2])
                    + (r_prod[3] + r_prod[4] + r_prod[5])
                    + (r_prod[6] + r_prod[7] + r_prod[8]);
            r_ctr3 <= r_ctr2;
        end
    end

    assign o_sum    = r_sum;
    assign o_center = r_ctr3;

endmodule

// ===== sv/gcf_emit.sv =====
`timescale 1ns / 1ps
// result slot: holds the up to three results of one pixel, one beat per cycle while i_out_ready is high
// depends on gcf_pkg
module gcf_emit import gcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_result            i_res [3],
    input  logic [2:0]         i_mask,
    output logic               o_can_load,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PIX_W-1:0]   o_pixel_out,
    output logic [COORD_W-1:0] o_out_row,
    output logic [COORD_W-1:0] o_out_col,
    output logic               o_clamped,
    output logic               o_last_of_run,
    output logic               o_end_of_image
);

    t_result    r_res [3];
    logic [2:0] r_pend;
    logic [2:0] clr;
    logic [2:0] rest;
    logic [1:0] sel;
    logic       take;
    logic       last;
    t_result    cur;

    always_comb begin
        if (r_pend[0]) begin
            sel = 2'd0;
            clr = 3'b001;
        end else if (r_pend[1]) begin
            sel = 2'd1;
            clr = 3'b010;
        end else begin
            sel = 2'd2;
            clr = 3'b100;
        end
    end

    assign rest        = r_pend & ~clr;
    assign last        = (rest == 3'b000);
    assign o_out_valid = |r_pend;
    assign take        = o_out_valid && i_out_ready;
    assign o_can_load  = !o_out_valid || (take && last);
    assign cur         = r_res[sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load && o_can_load) begin
            r_pend <= i_mask;
        end else if (take) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            for (int k = 0; k < 3; k++) begin
                r_res[k] <= i_res[k];
            end
        end
    end

    assign o_pixel_out    = cur.pix;
    assign o_out_row      = cur.row;
    assign o_out_col      = cur.col;
    assign o_clamped      = cur.clamped;
    assign o_end_of_image = cur.eoi;
    assign o_last_of_run  = last;

endmodule
